>>> rtl/char_lcd_nibble_queue_defines.svh
// ----------------------------------------------------------------------------
// char_lcd_nibble_queue_defines
// Assertion macros shared by the LCD nibble queue RTL.
// ----------------------------------------------------------------------------
`ifndef CHAR_LCD_NIBBLE_QUEUE_DEFINES_SVH
`define CHAR_LCD_NIBBLE_QUEUE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Check that cons holds in the same cycle as ante
`define CLQ_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("clq assertion failed");

// Check that cons holds in the cycle after ante
`define CLQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("clq assertion failed");

`else

`define CLQ_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define CLQ_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> rtl/clq_pkg.sv
// ----------------------------------------------------------------------------
// clq_pkg
// Types and constants for the character LCD nibble queue.
// ----------------------------------------------------------------------------
package clq_pkg;

  // Input transaction kinds
  localparam logic KIND_ENQ = 1'b0;
  localparam logic KIND_DEQ = 1'b1;

  // LCD port bits
  localparam logic [7:0] RS_BIT   = 8'h10;
  localparam logic [7:0] EN_BIT   = 8'h40;
  localparam logic [7:0] PORT_IDLE = 8'h00;

  // Write sequence steps
  localparam int unsigned STEP_W = 3;
  localparam logic [STEP_W-1:0] STEP_HI    = 3'd0;
  localparam logic [STEP_W-1:0] STEP_HI_EN = 3'd1;
  localparam logic [STEP_W-1:0] STEP_HI_LO = 3'd2;
  localparam logic [STEP_W-1:0] STEP_LO    = 3'd3;
  localparam logic [STEP_W-1:0] STEP_LO_EN = 3'd4;
  localparam logic [STEP_W-1:0] STEP_LO_LO = 3'd5;
  localparam logic [STEP_W-1:0] STEP_LAST  = 3'd6;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] port_value;
    logic       last_write;
  } out_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } state_t;

endpackage

>>> rtl/clq_ram.sv
// ----------------------------------------------------------------------------
// clq_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module clq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read, hold data between reads
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/char_lcd_nibble_queue.sv
// The first port write of a byte is presented in the cycle after its dequeue transaction.
// While the one write sequencer emits a byte's port writes, no new enqueue or
// dequeue is accepted; an enqueue or an empty dequeue leaves the sequencer idle.
// Reset: synchronous active-low rst_n clears indices, fill count and sequencer;
// queue RAM contents are not cleared and no clearing pass runs.
// ----------------------------------------------------------------------------
// char_lcd_nibble_queue
// Ring FIFO of LCD bytes in RAM feeding a 4-bit character LCD write sequencer.
// ----------------------------------------------------------------------------
`include "char_lcd_nibble_queue_defines.svh"

module char_lcd_nibble_queue #(
  parameter int unsigned QUEUE_DEPTH = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  clq_pkg::in_t in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output clq_pkg::out_t out_data
);

  import clq_pkg::*;

  localparam int unsigned IDX_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  state_t             state_r, state_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic [IDX_W-1:0]   wr_idx_r, wr_idx_nxt;
  logic [IDX_W-1:0]   rd_idx_r, rd_idx_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;

  logic               in_acc;
  logic               out_acc;
  logic               full;
  logic               empty;
  logic               wr_en;
  logic               rd_en;
  logic [7:0]         ram_q;
  logic [7:0]         hi_val;
  logic [7:0]         lo_val;

  // Queue storage
  clq_ram #(
    .WIDTH (8),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_idx_r),
    .wr_data (in_data.data_byte),
    .rd_en   (rd_en),
    .rd_addr (rd_idx_r),
    .rd_data (ram_q)
  );

  // Handshake and queue status
  always_comb begin
    in_ready  = (state_r == ST_IDLE);
    out_valid = (state_r == ST_EMIT);
    in_acc    = in_valid && in_ready;
    out_acc   = out_valid && out_ready;
    full      = (cnt_r == CNT_FULL);
    empty     = (cnt_r == '0);
    wr_en     = in_acc && (in_data.kind == KIND_ENQ) && !full;
    rd_en     = in_acc && (in_data.kind == KIND_DEQ) && !empty;
  end

  // Advance indices and fill count
  always_comb begin
    wr_idx_nxt = wr_idx_r;
    rd_idx_nxt = rd_idx_r;
    cnt_nxt    = cnt_r;
    if (wr_en) begin
      wr_idx_nxt = (wr_idx_r == IDX_MAX) ? '0 : wr_idx_r + 1'b1;
      cnt_nxt    = cnt_r + 1'b1;
    end
    if (rd_en) begin
      rd_idx_nxt = (rd_idx_r == IDX_MAX) ? '0 : rd_idx_r + 1'b1;
      cnt_nxt    = cnt_r - 1'b1;
    end
  end

  // Sequencer: step through the seven port writes
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    case (state_r)
      ST_IDLE: begin
        if (rd_en) begin
          state_nxt = ST_EMIT;
          step_nxt  = STEP_HI;
        end
      end
      ST_EMIT: begin
        if (out_acc) begin
          if (step_r == STEP_LAST) begin
            state_nxt = ST_IDLE;
          end else begin
            step_nxt = step_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      step_r   <= STEP_HI;
      wr_idx_r <= '0;
      rd_idx_r <= '0;
      cnt_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      step_r   <= step_nxt;
      wr_idx_r <= wr_idx_nxt;
      rd_idx_r <= rd_idx_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Build nibble writes; RS marks display data (byte bit 7 clear)
  always_comb begin
    hi_val = {4'h0, ram_q[7:4]};
    if (!ram_q[7]) begin
      hi_val = hi_val | RS_BIT;
    end
    lo_val = {hi_val[7:4], ram_q[3:0]};
    out_data.last_write = 1'b0;
    case (step_r)
      STEP_HI:    out_data.port_value = hi_val;
      STEP_HI_EN: out_data.port_value = hi_val | EN_BIT;
      STEP_HI_LO: out_data.port_value = hi_val;
      STEP_LO:    out_data.port_value = lo_val;
      STEP_LO_EN: out_data.port_value = lo_val | EN_BIT;
      STEP_LO_LO: out_data.port_value = lo_val;
      STEP_LAST: begin
        out_data.port_value = PORT_IDLE;
        out_data.last_write = 1'b1;
      end
      default:    out_data.port_value = PORT_IDLE;
    endcase
  end

  // Assertions
  `CLQ_ASSERT_IMPL(a_cnt_range, clk, rst_n, 1'b1, cnt_r <= CNT_FULL)
  `CLQ_ASSERT_IMPL(a_empty_idx, clk, rst_n, empty, wr_idx_r == rd_idx_r)
  `CLQ_ASSERT_NEXT(a_drop_full, clk, rst_n, in_acc && (in_data.kind == KIND_ENQ) && full, $stable(cnt_r) && $stable(wr_idx_r))
  `CLQ_ASSERT_NEXT(a_deq_emit, clk, rst_n, rd_en, out_valid && (step_r == STEP_HI))
  `CLQ_ASSERT_NEXT(a_last_idle, clk, rst_n, out_acc && (step_r == STEP_LAST), in_ready)

endmodule
